// ----- rtl/core/scl_pkg.sv -----
package scl_pkg;

	localparam int MAX_SETS   = 256;
	localparam int MAX_WAYS   = 8;
	localparam int ADDR_W     = 64;
	localparam int SET_W      = $clog2(MAX_SETS);
	localparam int WAY_W      = $clog2(MAX_WAYS);
	localparam int WAY_CNT_W  = WAY_W + 1;
	localparam int AGE_W      = 3;
	localparam int TAG_W      = 62;
	localparam int TOTAL_W    = 32;

	localparam int SB_CFG_W   = 4;
	localparam int WAYS_CFG_W = 4;
	localparam int BB_CFG_W   = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [SB_CFG_W-1:0]   SB_MIN   = SB_CFG_W'(1);
	localparam logic [SB_CFG_W-1:0]   SB_MAX   = SB_CFG_W'(SET_W);
	localparam logic [WAYS_CFG_W-1:0] WAYS_MIN = WAYS_CFG_W'(1);
	localparam logic [WAYS_CFG_W-1:0] WAYS_MAX = WAYS_CFG_W'(MAX_WAYS);
	localparam logic [BB_CFG_W-1:0]   BB_MIN   = BB_CFG_W'(1);
	localparam logic [BB_CFG_W-1:0]   BB_MAX   = BB_CFG_W'(16);

	localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_FETCH  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = CFG_IDX_W'(2);

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	typedef struct packed {
		logic hit;
		logic evict;
		row_t row;
	} lookup_t;

endpackage

// ----- rtl/core/set_assoc_cache_lru_model.sv -----
// Cache simulator with true least-recently-used replacement over up to 256 sets of
// eight ways. An item is accepted when start is high and busy is low; its result is
// shown on the output ports for exactly one cycle while done is high, and cannot be
// held off. A load or store runs the split, read and look states; a modify runs
// split, then read and look twice (each lookup is a set read and a write-back
// through the tag store); a fetch gives done from idle. A new item may be started in
// the cycle in which done is high. The tag store needs no clearing pass after reset.
// Configuration must be written only while busy is low; the block does not enforce it.
module set_assoc_cache_lru_model
	import scl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	input  logic [1:0]            command,
	input  logic [ADDR_W-1:0]     address,
	output logic                  busy,
	output logic                  done,
	output logic [1:0]            hits_now,
	output logic                  missed,
	output logic                  evicted,
	output logic [TOTAL_W-1:0]    total_hits,
	output logic [TOTAL_W-1:0]    total_misses,
	output logic [TOTAL_W-1:0]    total_evictions
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_READ,
		ST_LOOK
	} state_t;

	state_t                  state_q;
	logic [SB_CFG_W-1:0]     set_bits_q;
	logic [WAYS_CFG_W-1:0]   ways_used_q;
	logic [BB_CFG_W-1:0]     block_bits_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    twice_q;
	logic                    second_q;
	logic [SET_W-1:0]        set_q;
	logic [TAG_W-1:0]        tag_q;
	logic [TOTAL_W-1:0]      hit_total_q;
	logic [TOTAL_W-1:0]      miss_total_q;
	logic [TOTAL_W-1:0]      evict_total_q;

	logic [SB_CFG_W-1:0]     sb;
	logic [WAYS_CFG_W-1:0]   ways;
	logic [BB_CFG_W-1:0]     bb;
	logic [5:0]              tag_shift;
	logic [SET_W:0]          set_mask;
	logic [SET_W-1:0]        set_idx;
	logic [TAG_W-1:0]        tag_val;
	row_t                    rd_row;
	lookup_t                 lk;
	logic [TOTAL_W-1:0]      hit_total_nx;
	logic [TOTAL_W-1:0]      miss_total_nx;
	logic [TOTAL_W-1:0]      evict_total_nx;

	always_comb begin
		sb   = (set_bits_q < SB_MIN) ? SB_MIN : (set_bits_q > SB_MAX) ? SB_MAX : set_bits_q;
		ways = (ways_used_q < WAYS_MIN) ? WAYS_MIN
			: (ways_used_q > WAYS_MAX) ? WAYS_MAX : ways_used_q;
		bb   = (block_bits_q < BB_MIN) ? BB_MIN
			: (block_bits_q > BB_MAX) ? BB_MAX : block_bits_q;
	end

	assign tag_shift = {2'b00, sb} + {1'b0, bb};
	assign set_mask  = ((SET_W + 1)'(1) << sb) - (SET_W + 1)'(1);
	assign set_idx   = SET_W'(addr_q >> bb) & set_mask[SET_W-1:0];
	assign tag_val   = TAG_W'(addr_q >> tag_shift);

	scl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_READ),
		.rd_addr (set_q),
		.wr_en   (state_q == ST_LOOK),
		.wr_addr (set_q),
		.wr_data (lk.row),
		.rd_data (rd_row)
	);

	scl_lookup u_lookup (
		.row  (rd_row),
		.tag  (tag_q),
		.ways (ways),
		.res  (lk)
	);

	always_comb begin
		hit_total_nx   = hit_total_q;
		miss_total_nx  = miss_total_q;
		evict_total_nx = evict_total_q;
		if (lk.hit && (hit_total_q != TOTAL_MAX)) begin
			hit_total_nx = hit_total_q + TOTAL_W'(1);
		end
		if (!lk.hit && (miss_total_q != TOTAL_MAX)) begin
			miss_total_nx = miss_total_q + TOTAL_W'(1);
		end
		if (lk.evict && (evict_total_q != TOTAL_MAX)) begin
			evict_total_nx = evict_total_q + TOTAL_W'(1);
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			set_bits_q      <= SB_CFG_W'(4);
			ways_used_q     <= WAYS_CFG_W'(1);
			block_bits_q    <= BB_CFG_W'(4);
			addr_q          <= '0;
			twice_q         <= 1'b0;
			second_q        <= 1'b0;
			set_q           <= '0;
			tag_q           <= '0;
			hit_total_q     <= '0;
			miss_total_q    <= '0;
			evict_total_q   <= '0;
			done            <= 1'b0;
			hits_now        <= '0;
			missed          <= 1'b0;
			evicted         <= 1'b0;
			total_hits      <= '0;
			total_misses    <= '0;
			total_evictions <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SET_BITS: begin
						set_bits_q <= cfg_data[SB_CFG_W-1:0];
					end
					REG_WAYS_USED: begin
						ways_used_q <= cfg_data[WAYS_CFG_W-1:0];
					end
					REG_BLOCK_BITS: begin
						block_bits_q <= cfg_data[BB_CFG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					done <= start && (command == CMD_FETCH);
					if (start) begin
						hits_now <= '0;
						missed   <= 1'b0;
						evicted  <= 1'b0;
						if (command == CMD_FETCH) begin
							total_hits      <= hit_total_q;
							total_misses    <= miss_total_q;
							total_evictions <= evict_total_q;
						end else begin
							addr_q   <= address;
							twice_q  <= (command == CMD_MODIFY);
							second_q <= 1'b0;
							state_q  <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: begin
					done    <= 1'b0;
					set_q   <= set_idx;
					tag_q   <= tag_val;
					state_q <= ST_READ;
				end
				ST_READ: begin
					done    <= 1'b0;
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					hit_total_q   <= hit_total_nx;
					miss_total_q  <= miss_total_nx;
					evict_total_q <= evict_total_nx;
					hits_now      <= hits_now + {1'b0, lk.hit};
					missed        <= missed | !lk.hit;
					evicted       <= evicted | lk.evict;
					if (twice_q && !second_q) begin
						done     <= 1'b0;
						second_q <= 1'b1;
						state_q  <= ST_READ;
					end else begin
						done            <= 1'b1;
						total_hits      <= hit_total_nx;
						total_misses    <= miss_total_nx;
						total_evictions <= evict_total_nx;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					done    <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/scl_store.sv -----
module scl_store
	import scl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_addr,
	input  row_t             wr_data,
	output row_t             rd_data
);

	row_t                mem [MAX_SETS];
	row_t                rd_data_q;
	logic [MAX_SETS-1:0] row_vld_q;
	logic                rd_vld_q;

	// A set that has never been written reads as all lines invalid.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/scl_lookup.sv -----
module scl_lookup
	import scl_pkg::*;
(
	input  row_t                 row,
	input  logic [TAG_W-1:0]     tag,
	input  logic [WAY_CNT_W-1:0] ways,
	output lookup_t              res
);

	always_comb begin
		logic [MAX_WAYS-1:0] inuse;
		logic [MAX_WAYS-1:0] hitv;
		logic                found;
		logic [WAY_W-1:0]    hw;
		logic [AGE_W-1:0]    old_age;
		logic                have_e;
		logic [WAY_W-1:0]    ew;
		logic                have_v;
		logic [WAY_W-1:0]    vw;
		logic [AGE_W-1:0]    oldest;
		logic [WAY_W-1:0]    victim;
		logic                bump;

		found  = 1'b0;
		hw     = '0;
		have_e = 1'b0;
		ew     = '0;
		have_v = 1'b0;
		vw     = '0;
		oldest = '0;

		for (int w = 0; w < MAX_WAYS; w++) begin
			inuse[w] = WAY_CNT_W'(w) < ways;
			hitv[w]  = inuse[w] && row[w].valid && (row[w].tag == tag);
		end

		for (int w = 0; w < MAX_WAYS; w++) begin
			if (hitv[w] && !found) begin
				found = 1'b1;
				hw    = WAY_W'(w);
			end
		end
		old_age = row[hw].age;

		// Victim is the lowest invalid way, else the oldest valid way (lowest on ties).
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (inuse[w]) begin
				if (!row[w].valid) begin
					if (!have_e) begin
						have_e = 1'b1;
						ew     = WAY_W'(w);
					end
				end else if (!have_v || row[w].age > oldest) begin
					have_v = 1'b1;
					oldest = row[w].age;
					vw     = WAY_W'(w);
				end
			end
		end
		victim = have_e ? ew : vw;

		res.hit   = found;
		res.evict = !found && !have_e;
		res.row   = row;

		for (int w = 0; w < MAX_WAYS; w++) begin
			if (found) begin
				bump = (WAY_W'(w) != hw) && inuse[w] && row[w].valid
					&& (row[w].age < old_age);
			end else begin
				bump = (WAY_W'(w) != victim) && inuse[w] && row[w].valid;
			end
			if (bump && (row[w].age != AGE_MAX)) begin
				res.row[w].age = row[w].age + AGE_W'(1);
			end
		end

		if (found) begin
			res.row[hw].age = '0;
		end else begin
			res.row[victim].valid = 1'b1;
			res.row[victim].tag   = tag;
			res.row[victim].age   = '0;
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import scl_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 70;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] addr;
		int          gap;
		bit          drain;
	} access_t;

	typedef struct {
		logic [1:0]  hits_now;
		logic        missed;
		logic        evicted;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
		logic [31:0] total_evictions;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic [1:0]            command = CMD_LOAD;
	logic [ADDR_W-1:0]     address = '0;
	logic                  busy;
	logic                  done;
	logic [1:0]            hits_now;
	logic                  missed;
	logic                  evicted;
	logic [TOTAL_W-1:0]    total_hits;
	logic [TOTAL_W-1:0]    total_misses;
	logic [TOTAL_W-1:0]    total_evictions;

	set_assoc_cache_lru_model u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start           (start),
		.command         (command),
		.address         (address),
		.busy            (busy),
		.done            (done),
		.hits_now        (hits_now),
		.missed          (missed),
		.evicted         (evicted),
		.total_hits      (total_hits),
		.total_misses    (total_misses),
		.total_evictions (total_evictions)
	);

	always #2 clk = ~clk;

	// Shadow copy of the cache and its configuration.
	logic        tag_valid [MAX_SETS*MAX_WAYS];
	logic [63:0] tag_store [MAX_SETS*MAX_WAYS];
	logic [2:0]  line_age  [MAX_SETS*MAX_WAYS];
	logic [31:0] hit_count = '0;
	logic [31:0] miss_count = '0;
	logic [31:0] evict_count = '0;
	logic [3:0]  cfg_set_bits = 4'd4;
	logic [3:0]  cfg_ways = 4'd1;
	logic [4:0]  cfg_block_bits = 5'd4;

	access_t  pending_q [$];
	outcome_t expect_q [$];

	int  errors = 0;
	int  results_checked = 0;
	int  settings_written = 0;
	int  cmd_count [4] = '{0, 0, 0, 0};
	int  gap_left = 0;
	bit  pause = 1'b0;
	int  idle_cycles = 0;

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void effective_cfg(output int sb, output int nw, output int bb);
		sb = clamp_int(int'(cfg_set_bits), 1, 8);
		nw = clamp_int(int'(cfg_ways), 1, MAX_WAYS);
		bb = clamp_int(int'(cfg_block_bits), 1, 16);
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == TOTAL_MAX) ? v : v + 32'd1;
	endfunction

	// One lookup in the selected set; returns 1 on a hit and flags an eviction.
	function automatic bit probe_set(logic [63:0] a, output bit ev);
		int          sb, nw, bb, base, empty, victim;
		logic [63:0] set_i, tg;
		logic [2:0]  old, oldest;
		bit          have;
		effective_cfg(sb, nw, bb);
		set_i = (a >> bb) & ((64'd1 << sb) - 64'd1);
		tg = a >> (sb + bb);
		base = int'(set_i) * MAX_WAYS;
		ev = 1'b0;
		for (int w = 0; w < nw; w++) begin
			if (tag_valid[base+w] && tag_store[base+w] == tg) begin
				old = line_age[base+w];
				for (int k = 0; k < nw; k++) begin
					if (k != w && tag_valid[base+k] && line_age[base+k] < old &&
					    line_age[base+k] != AGE_MAX)
						line_age[base+k] = line_age[base+k] + 3'd1;
				end
				line_age[base+w] = '0;
				hit_count = sat_inc(hit_count);
				return 1'b1;
			end
		end
		miss_count = sat_inc(miss_count);
		empty = -1;
		victim = 0;
		oldest = '0;
		have = 1'b0;
		for (int w = 0; w < nw; w++) begin
			if (!tag_valid[base+w]) begin
				if (empty < 0)
					empty = w;
			end else if (!have || line_age[base+w] > oldest) begin
				have = 1'b1;
				oldest = line_age[base+w];
				victim = w;
			end
		end
		if (empty >= 0) begin
			victim = empty;
		end else begin
			ev = 1'b1;
			evict_count = sat_inc(evict_count);
		end
		for (int w = 0; w < nw; w++) begin
			if (w != victim && tag_valid[base+w] && line_age[base+w] != AGE_MAX)
				line_age[base+w] = line_age[base+w] + 3'd1;
		end
		tag_valid[base+victim] = 1'b1;
		tag_store[base+victim] = tg;
		line_age[base+victim] = '0;
		return 1'b0;
	endfunction

	function automatic outcome_t expected_outcome(logic [1:0] cmd, logic [63:0] a);
		outcome_t r;
		int       n;
		bit       ev;
		r.hits_now = '0;
		r.missed = 1'b0;
		r.evicted = 1'b0;
		n = (cmd == CMD_MODIFY) ? 2 : (cmd == CMD_FETCH) ? 0 : 1;
		for (int k = 0; k < n; k++) begin
			if (probe_set(a, ev)) begin
				r.hits_now = r.hits_now + 2'd1;
			end else begin
				r.missed = 1'b1;
				if (ev)
					r.evicted = 1'b1;
			end
		end
		r.total_hits = hit_count;
		r.total_misses = miss_count;
		r.total_evictions = evict_count;
		return r;
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Addresses mostly reuse a few tags in a few sets so that sets fill and lines age.
	function automatic logic [63:0] gen_address(logic [63:0] tag_base);
		int          sb, nw, bb;
		logic [63:0] tg, st, off;
		effective_cfg(sb, nw, bb);
		if ($urandom_range(0, 9) == 0)
			return {$urandom(), $urandom()};
		tg = tag_base ^ 64'($urandom_range(0, nw + 2));
		st = ($urandom_range(0, 3) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 2));
		st = st & ((64'd1 << sb) - 64'd1);
		off = {$urandom(), $urandom()} & ((64'd1 << bb) - 64'd1);
		return (tg << (sb + bb)) | (st << bb) | off;
	endfunction

	function automatic logic [1:0] pick_command();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return CMD_LOAD;
		if (r < 6)
			return CMD_STORE;
		if (r < 9)
			return CMD_MODIFY;
		return CMD_FETCH;
	endfunction

	task automatic queue_item(logic [1:0] cmd, logic [63:0] a, bit calm, bit drain);
		access_t it;
		it.cmd = cmd;
		it.addr = a;
		it.gap = pick_gap(calm);
		it.drain = drain;
		pending_q.push_back(it);
	endtask

	task automatic flag_error(string what, logic [63:0] want, logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SET_BITS: cfg_set_bits = val[3:0];
			REG_WAYS_USED: cfg_ways = val[3:0];
			REG_BLOCK_BITS: cfg_block_bits = val;
			default: ;
		endcase
		settings_written++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || start || expect_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Driver.
	always @(posedge clk) begin
		access_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				expect_q.push_back(expected_outcome(command, address));
				cmd_count[command]++;
			end
			if (!(start && busy)) begin
				if (pause && expect_q.size() != 0) begin
					start <= 1'b0;
				end else if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_q.size() != 0) begin
					nxt = pending_q.pop_front();
					start <= 1'b1;
					command <= nxt.cmd;
					address <= nxt.addr;
					gap_left <= nxt.gap;
					pause <= nxt.drain;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			results_checked++;
			if (expect_q.size() == 0) begin
				flag_error("unexpected result, total_hits", '0, total_hits);
			end else begin
				e = expect_q.pop_front();
				if (hits_now !== e.hits_now)
					flag_error("hits_now", e.hits_now, hits_now);
				if (missed !== e.missed)
					flag_error("missed", e.missed, missed);
				if (evicted !== e.evicted)
					flag_error("evicted", e.evicted, evicted);
				if (total_hits !== e.total_hits)
					flag_error("total_hits", e.total_hits, total_hits);
				if (total_misses !== e.total_misses)
					flag_error("total_misses", e.total_misses, total_misses);
				if (total_evictions !== e.total_evictions)
					flag_error("total_evictions", e.total_evictions, total_evictions);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
				$display("** set_assoc_cache_lru_model: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int          setting [9][3];
		int          n_real, i;
		logic [1:0]  cmd;
		logic [63:0] tag_base;
		setting = '{'{1, 1, 1}, '{8, 8, 16}, '{0, 0, 0}, '{2, 4, 3},
		            '{15, 15, 31}, '{3, 8, 2}, '{8, 2, 1}, '{0, 0, 0},
		            '{0, 0, 0}};
		for (int j = 0; j < MAX_SETS * MAX_WAYS; j++) begin
			tag_valid[j] = 1'b0;
			tag_store[j] = '0;
			line_age[j] = '0;
		end
		for (int p = 7; p < 9; p++) begin
			setting[p][0] = $urandom_range(0, 31);
			setting[p][1] = $urandom_range(0, 31);
			setting[p][2] = $urandom_range(0, 31);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_item(CMD_LOAD, 64'h0, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 64'h0, 1'b0, 1'b0);
		queue_item(CMD_STORE, 64'hF, 1'b0, 1'b0);
		queue_item(CMD_MODIFY, 64'h8, 1'b0, 1'b0);
		queue_item(CMD_FETCH, 64'h0, 1'b0, 1'b0);
		queue_item(CMD_FETCH, '1, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 64'h100, 1'b0, 1'b0);
		queue_item(CMD_MODIFY, 64'h0, 1'b0, 1'b0);
		queue_item(CMD_MODIFY, 64'h210, 1'b0, 1'b0);
		queue_item(CMD_LOAD, '1, 1'b0, 1'b0);
		queue_item(CMD_STORE, '1, 1'b0, 1'b0);
		queue_item(CMD_STORE, 64'h8000_0000_0000_00F0, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FF0F, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
		queue_item(CMD_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
		queue_item(CMD_MODIFY, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
		queue_item(CMD_LOAD, 64'h0, 1'b0, 1'b1);
		queue_item(CMD_FETCH, 64'h1234, 1'b0, 1'b0);
		queue_item(CMD_MODIFY, 64'h0, 1'b0, 1'b0);
		wait_drained();

		for (int p = 0; p < 9; p++) begin
			write_reg(REG_SET_BITS, CFG_DATA_W'(setting[p][0]));
			write_reg(REG_WAYS_USED, CFG_DATA_W'(setting[p][1]));
			write_reg(REG_BLOCK_BITS, CFG_DATA_W'(setting[p][2]));
			@(posedge clk);
			cfg_write <= 1'b0;
			repeat (2) @(posedge clk);
			tag_base = {$urandom(), $urandom()};
			n_real = 0;
			i = 0;
			while (n_real < PHASE_ITEMS) begin
				cmd = pick_command();
				if (cmd != CMD_FETCH)
					n_real++;
				queue_item(cmd, gen_address(tag_base), ((i / 32) % 4) == 3,
				           $urandom_range(0, 79) == 0);
				i++;
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		while (expect_q.size() != 0)
			flag_error("result never arrived, total_hits", expect_q.pop_front().total_hits, '0);
		$display("%0d loads, %0d stores, %0d modifies and %0d fetches over %0d register writes;",
		         cmd_count[CMD_LOAD], cmd_count[CMD_STORE], cmd_count[CMD_MODIFY],
		         cmd_count[CMD_FETCH], settings_written);
		$display("%0d results checked, %0d mismatches.", results_checked, errors);
		if (errors == 0)
			$display("** set_assoc_cache_lru_model: PASSED **");
		else
			$display("** set_assoc_cache_lru_model: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/scl_pkg.sv
rtl/core/scl_store.sv
rtl/core/scl_lookup.sv
rtl/core/set_assoc_cache_lru_model.sv
tb/sv/tb.sv
